[hdl/crc16fc_pkg.sv]
package crc16fc_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CrcW    = 16;
	localparam int unsigned OutW    = 24;
	localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
	localparam logic [CrcW-1:0] CrcTop  = 16'h8000;

	// frame position: header bytes 0..3, crc bytes 4..5, then payload
	typedef enum logic [2:0] {
		POS_HDR0    = 3'd0,
		POS_HDR1    = 3'd1,
		POS_LEN_LO  = 3'd2,
		POS_LEN_HI  = 3'd3,
		POS_CRC_LO  = 3'd4,
		POS_CRC_HI  = 3'd5,
		POS_PAYLOAD = 3'd6
	} pos_t;

	// verdict handed from the frame tracker to the output register
	typedef struct packed {
		logic            valid;
		logic            crc_ok;
		logic [CrcW-1:0] computed_crc;
	} verdict_t;

endpackage

[hdl/crc16_frame_checker_core.sv]
// crc16 frame checker
// input stream: one frame byte per word on s_tdata. a frame is four header
// bytes (bytes 2 and 3 give the payload length, little-endian), a received
// crc-16 in bytes 4 and 5 (little-endian), then the payload. frames follow
// each other with no gap.
// output stream: one word per frame, on its last byte. m_tdata bit 0 is
// crc_ok, bits 16:1 the crc-16 (poly 0x1021, init 0, msb first) over header
// and payload, bytes 4 and 5 excluded. a zero length ends the frame at byte 5.
// path: a byte is held in the input register and is then processed into the
// result register, which holds the verdict on m_tdata.
// throughput: one byte per clock while m_tready is high; the byte crc is
// one combinational 8-step shift between the input and result registers.
// while a verdict waits on a low m_tready the tracker holds; s_tready is low
// whenever the input register is then full, so at most one more byte enters
// and nothing is lost or repeated.
// reset: arst_n clears all frame state; the first byte after reset is
// byte 0 of a frame.
module crc16_frame_checker_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [crc16fc_pkg::ByteW-1:0]    s_tdata,  // [7:0] data_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [crc16fc_pkg::OutW-1:0]     m_tdata   // [0] crc_ok, [16:1] computed_crc
);

	logic                          valid_s1;
	logic [crc16fc_pkg::ByteW-1:0] byte_s1;
	logic                          advance;
	crc16fc_pkg::verdict_t         verdict;
	logic                          m_valid_q;
	logic                          ok_q;
	logic [crc16fc_pkg::CrcW-1:0]  crc_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	crc16fc_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.data_byte(byte_s1),
		.verdict  (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && verdict.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && verdict.valid) begin
			ok_q  <= verdict.crc_ok;
			crc_q <= verdict.computed_crc;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, crc_q, ok_q};

`ifndef SYNTHESIS
	// a held byte stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input byte dropped while stalled");

	// with the result register empty the input side is always open
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input blocked with empty result register");

	// a processed verdict reaches the output
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && verdict.valid |=> m_valid_q)
		else $error("verdict lost");

	// the tracker never advances without a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("tracker advanced without a byte");
`endif

endmodule

[hdl/crc16fc_crc8.sv]
module crc16fc_crc8 (
	input  logic [crc16fc_pkg::CrcW-1:0]  crc_in,
	input  logic [crc16fc_pkg::ByteW-1:0] data_byte,
	output logic [crc16fc_pkg::CrcW-1:0]  crc_out
);

	// eight msb-first shift steps of the 0x1021 polynomial
	always_comb begin
		logic [crc16fc_pkg::CrcW-1:0] c;
		c = crc_in ^ {data_byte, 8'h00};
		for (int k = 0; k < crc16fc_pkg::ByteW; k++) begin
			if ((c & crc16fc_pkg::CrcTop) != '0) begin
				c = {c[crc16fc_pkg::CrcW-2:0], 1'b0} ^ crc16fc_pkg::CrcPoly;
			end else begin
				c = {c[crc16fc_pkg::CrcW-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

[hdl/crc16fc_tracker.sv]
module crc16fc_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [crc16fc_pkg::ByteW-1:0] data_byte,
	output crc16fc_pkg::verdict_t         verdict
);

	crc16fc_pkg::pos_t             pos_q, pos_d;
	logic [crc16fc_pkg::CrcW-1:0]  rem_q, rem_d;
	logic [crc16fc_pkg::CrcW-1:0]  crc_q, crc_d;
	logic [crc16fc_pkg::CrcW-1:0]  rcv_q, rcv_d;
	logic [crc16fc_pkg::ByteW-1:0] len_lo_q, len_lo_d;
	logic [crc16fc_pkg::CrcW-1:0]  crc_in;
	logic [crc16fc_pkg::CrcW-1:0]  crc_next;
	logic [crc16fc_pkg::CrcW-1:0]  rem_dec;
	logic [crc16fc_pkg::CrcW-1:0]  rcv_full;

	// an unknown position restarts the crc from zero
	assign crc_in   = (pos_q == crc16fc_pkg::POS_HDR0 || pos_q == crc16fc_pkg::POS_HDR1 ||
		pos_q == crc16fc_pkg::POS_LEN_LO || pos_q == crc16fc_pkg::POS_LEN_HI ||
		pos_q == crc16fc_pkg::POS_CRC_LO || pos_q == crc16fc_pkg::POS_CRC_HI ||
		pos_q == crc16fc_pkg::POS_PAYLOAD) ? crc_q : '0;
	assign rem_dec  = rem_q - 16'd1;
	assign rcv_full = {data_byte, rcv_q[crc16fc_pkg::ByteW-1:0]};

	crc16fc_crc8 u_crc8 (
		.crc_in   (crc_in),
		.data_byte(data_byte),
		.crc_out  (crc_next)
	);

	// verdict on the last byte of a frame
	always_comb begin
		verdict = '0;
		unique case (pos_q)
			crc16fc_pkg::POS_CRC_HI: begin
				verdict.valid        = (rem_q == '0);
				verdict.crc_ok       = (crc_q == rcv_full);
				verdict.computed_crc = crc_q;
			end
			crc16fc_pkg::POS_PAYLOAD: begin
				verdict.valid        = (rem_dec == '0);
				verdict.crc_ok       = (crc_next == rcv_q);
				verdict.computed_crc = crc_next;
			end
			default: begin
				verdict = '0;
			end
		endcase
	end

	// next frame state
	always_comb begin
		pos_d    = pos_q;
		rem_d    = rem_q;
		crc_d    = crc_q;
		rcv_d    = rcv_q;
		len_lo_d = len_lo_q;
		unique case (pos_q)
			crc16fc_pkg::POS_HDR0: begin
				crc_d = crc_next;
				pos_d = crc16fc_pkg::POS_HDR1;
			end
			crc16fc_pkg::POS_HDR1: begin
				crc_d = crc_next;
				pos_d = crc16fc_pkg::POS_LEN_LO;
			end
			crc16fc_pkg::POS_LEN_LO: begin
				crc_d    = crc_next;
				len_lo_d = data_byte;
				pos_d    = crc16fc_pkg::POS_LEN_HI;
			end
			crc16fc_pkg::POS_LEN_HI: begin
				crc_d = crc_next;
				rem_d = {data_byte, len_lo_q};
				pos_d = crc16fc_pkg::POS_CRC_LO;
			end
			crc16fc_pkg::POS_CRC_LO: begin
				rcv_d = {8'h00, data_byte};
				pos_d = crc16fc_pkg::POS_CRC_HI;
			end
			crc16fc_pkg::POS_CRC_HI: begin
				rcv_d = rcv_full;
				pos_d = crc16fc_pkg::POS_PAYLOAD;
			end
			crc16fc_pkg::POS_PAYLOAD: begin
				crc_d = crc_next;
				rem_d = rem_dec;
			end
			default: begin
				rem_d    = '0;
				rcv_d    = '0;
				len_lo_d = '0;
				crc_d    = crc_next;
				pos_d    = crc16fc_pkg::POS_HDR1;
			end
		endcase
		// frame done: back to byte 0 of the next frame
		if (verdict.valid) begin
			pos_d    = crc16fc_pkg::POS_HDR0;
			rem_d    = '0;
			crc_d    = '0;
			rcv_d    = '0;
			len_lo_d = '0;
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= crc16fc_pkg::POS_HDR0;
			rem_q    <= '0;
			crc_q    <= '0;
			rcv_q    <= '0;
			len_lo_q <= '0;
		end else if (en) begin
			pos_q    <= pos_d;
			rem_q    <= rem_d;
			crc_q    <= crc_d;
			rcv_q    <= rcv_d;
			len_lo_q <= len_lo_d;
		end
	end

endmodule
